>>> hw/rtl/qrs_pkg.sv
// ============================================================================
// qrs_pkg - shared types and constants for the quadratic root solver
// Solution class codes, internal root-formation modes and default widths.
// ============================================================================
`default_nettype none

package qrs_pkg;

    // default coefficient width and fraction bits of the results
    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    // fixed result field widths
    localparam int OUT_BITS   = 35;
    localparam int CLASS_BITS = 3;

    // solution class reported with each result word
    typedef enum logic [CLASS_BITS-1:0] {
        CLS_ALL     = 3'd0,   // every x solves it
        CLS_NONE    = 3'd1,   // no solution
        CLS_LINEAR  = 3'd2,   // one linear root
        CLS_DOUBLE  = 3'd3,   // double root
        CLS_REAL    = 3'd4,   // two real roots
        CLS_COMPLEX = 3'd5    // complex pair, real and imaginary part
    } t_class;

    // how the two quotients are formed once the square root is known
    typedef enum logic [2:0] {
        MD_ZERO,      // both results zero
        MD_LIN,       // -c/b, 0
        MD_CZERO,     // 0, -b/a
        MD_BZ_REAL,   // -s/(2|a|), s/(2|a|)
        MD_BZ_CPLX,   // 0, s/(2|a|)
        MD_DBL,       // -b/(2a) twice
        MD_REAL,      // (-b-s)/(2a), (-b+s)/(2a)
        MD_CPLX       // -b/(2a), s/(2a)
    } t_mode;

endpackage : qrs_pkg

`default_nettype wire

>>> hw/rtl/quadratic_root_solver.sv
// ============================================================================
// quadratic_root_solver - pipelined roots of a*x^2 + b*x + c = 0
// Classifies the equation and returns two rounded, saturated fixed-point roots.
// ============================================================================
// One coefficient word enters per clock and one result word leaves per clock
// while nothing stalls the pipe. It has SW square-root stages (one root bit
// each) and NW quotient stages (one quotient bit each, two dividers side by
// side). Both dividers share the denominator. A result holding in the output
// register does not stop the pipe: a one-word skid buffer takes the next
// result, and the pipe stalls only once that buffer is full. Roots carry
// FRAC_BITS fraction bits, round to nearest with ties away from zero and
// saturate to the 35-bit field range.
`default_nettype none

module quadratic_root_solver #(
    parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COEF_BITS-1:0]         i_coef_a,
    input  logic signed [COEF_BITS-1:0]         i_coef_b,
    input  logic signed [COEF_BITS-1:0]         i_coef_c,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [qrs_pkg::CLASS_BITS-1:0]      o_solution_class,
    output logic signed [qrs_pkg::OUT_BITS-1:0] o_root_first,
    output logic signed [qrs_pkg::OUT_BITS-1:0] o_root_second
);

    // widths
    localparam int CB  = COEF_BITS;
    localparam int PW  = 2 * CB;                    // product magnitude
    localparam int DW  = 2 * CB + 1;                // discriminant magnitude
    localparam int RW0 = DW + 2 * FRAC_BITS;
    localparam int RW  = RW0 + (RW0 % 2);           // radicand, even
    localparam int SW  = RW / 2;                    // square root
    localparam int NB  = CB + FRAC_BITS;
    localparam int NW  = ((NB > SW) ? NB : SW) + 2; // signed numerator
    localparam int UDW = CB + 1;                    // denominator magnitude
    localparam int DNW = CB + 2;                    // signed denominator
    localparam int OW  = qrs_pkg::OUT_BITS;
    localparam int XW  = ((NW > OW) ? NW : OW) + 1; // saturation compare

    logic en;
    logic r_o_vld, r_sk_vld;

    // ------------------------------------------------------------------
    // stage 1: register coefficients, form |b|^2 and |a||c|
    // ------------------------------------------------------------------
    logic [CB-1:0] w_ma_in, w_mb_in, w_mc_in;
    logic                 r1_vld;
    logic signed [CB-1:0] r1_a, r1_b, r1_c;
    logic [PW-1:0]        r1_bb, r1_ac;

    assign w_ma_in = i_coef_a[CB-1] ? $unsigned(-i_coef_a) : $unsigned(i_coef_a);
    assign w_mb_in = i_coef_b[CB-1] ? $unsigned(-i_coef_b) : $unsigned(i_coef_b);
    assign w_mc_in = i_coef_c[CB-1] ? $unsigned(-i_coef_c) : $unsigned(i_coef_c);

    assign en      = ~r_sk_vld;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a  <= i_coef_a;
            r1_b  <= i_coef_b;
            r1_c  <= i_coef_c;
            r1_bb <= PW'(w_mb_in) * PW'(w_mb_in);
            r1_ac <= PW'(w_ma_in) * PW'(w_mc_in);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: discriminant magnitude and sign, class and mode
    // ------------------------------------------------------------------
    logic [CB-1:0]          w_ma;
    logic [DW-1:0]          w_bbx, w_p4, w_dm;
    logic                   w_opp, w_ge, w_eq;
    logic signed [NW-1:0]   w_nb;
    logic signed [DNW-1:0]  w_den;
    qrs_pkg::t_class        w_cls;
    qrs_pkg::t_mode         w_mode;

    always_comb begin
        w_ma  = r1_a[CB-1] ? $unsigned(-r1_a) : $unsigned(r1_a);
        w_bbx = DW'(r1_bb);
        w_p4  = DW'(r1_ac) << 2;
        w_opp = r1_a[CB-1] ^ r1_c[CB-1];
        w_ge  = (w_bbx >= w_p4);
        w_eq  = (w_bbx == w_p4);
        if (w_opp) begin
            w_dm = w_bbx + w_p4;
        end else if (w_ge) begin
            w_dm = w_bbx - w_p4;
        end else begin
            w_dm = w_p4 - w_bbx;
        end

        w_nb  = -(NW'(r1_b) <<< FRAC_BITS);
        w_den = DNW'(r1_a) <<< 1;

        priority if (r1_a == '0) begin
            if (r1_b == '0) begin
                w_cls  = (r1_c == '0) ? qrs_pkg::CLS_ALL : qrs_pkg::CLS_NONE;
                w_mode = qrs_pkg::MD_ZERO;
            end else begin
                w_cls  = qrs_pkg::CLS_LINEAR;
                w_mode = qrs_pkg::MD_LIN;
                w_nb   = -(NW'(r1_c) <<< FRAC_BITS);
                w_den  = DNW'(r1_b);
            end
        end else if (r1_b == '0) begin
            w_den = DNW'({w_ma, 1'b0});
            if (r1_c == '0) begin
                w_cls  = qrs_pkg::CLS_DOUBLE;
                w_mode = qrs_pkg::MD_ZERO;
            end else if (w_opp) begin
                w_cls  = qrs_pkg::CLS_REAL;
                w_mode = qrs_pkg::MD_BZ_REAL;
            end else begin
                w_cls  = qrs_pkg::CLS_COMPLEX;
                w_mode = qrs_pkg::MD_BZ_CPLX;
            end
        end else if (r1_c == '0) begin
            w_cls  = qrs_pkg::CLS_REAL;
            w_mode = qrs_pkg::MD_CZERO;
            w_den  = DNW'(r1_a);
        end else if (w_opp) begin
            w_cls  = qrs_pkg::CLS_REAL;
            w_mode = qrs_pkg::MD_REAL;
        end else if (w_eq) begin
            w_cls  = qrs_pkg::CLS_DOUBLE;
            w_mode = qrs_pkg::MD_DBL;
        end else if (w_ge) begin
            w_cls  = qrs_pkg::CLS_REAL;
            w_mode = qrs_pkg::MD_REAL;
        end else begin
            w_cls  = qrs_pkg::CLS_COMPLEX;
            w_mode = qrs_pkg::MD_CPLX;
        end
    end

    // square-root pipe, index 0 is the stage-2 register
    logic                  r_sq_vld  [0:SW];
    logic [RW-1:0]         r_sq_rem  [0:SW];
    logic [SW-1:0]         r_sq_root [0:SW];
    qrs_pkg::t_class       r_sq_cls  [0:SW];
    qrs_pkg::t_mode        r_sq_mode [0:SW];
    logic signed [NW-1:0]  r_sq_nb   [0:SW];
    logic signed [DNW-1:0] r_sq_den  [0:SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= RW'(w_dm) << (2 * FRAC_BITS);
            r_sq_root[0] <= '0;
            r_sq_cls[0]  <= w_cls;
            r_sq_mode[0] <= w_mode;
            r_sq_nb[0]   <= w_nb;
            r_sq_den[0]  <= w_den;
        end
    end

    // ------------------------------------------------------------------
    // square root: one root bit per stage, remainder = x - root^2
    // ------------------------------------------------------------------
    for (genvar k = 0; k < SW; k++) begin : g_sq
        localparam int BIT = SW - 1 - k;
        logic [RW+1:0] w_trial;
        logic          w_take;

        always_comb begin
            w_trial = ((RW + 2)'(r_sq_root[k]) << (BIT + 1))
                    + ((RW + 2)'(1) << (2 * BIT));
            w_take  = ((RW + 2)'(r_sq_rem[k]) >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]  <= w_take ? RW'((RW + 2)'(r_sq_rem[k]) - w_trial)
                                         : r_sq_rem[k];
                r_sq_root[k+1] <= r_sq_root[k] | (SW'(w_take) << BIT);
                r_sq_cls[k+1]  <= r_sq_cls[k];
                r_sq_mode[k+1] <= r_sq_mode[k];
                r_sq_nb[k+1]   <= r_sq_nb[k];
                r_sq_den[k+1]  <= r_sq_den[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // setup: pick numerators, split into magnitude and sign, add half den
    // ------------------------------------------------------------------
    logic signed [NW-1:0] w_sx, w_num1, w_num2;
    logic                 w_z1, w_z2;
    logic [NW-1:0]        w_un1, w_un2;
    logic [UDW-1:0]       w_ud;
    logic signed [DNW-1:0] w_dsel;

    always_comb begin
        w_sx   = $signed(NW'(r_sq_root[SW]));
        w_dsel = r_sq_den[SW];
        w_num1 = '0;
        w_num2 = '0;
        w_z1   = 1'b0;
        w_z2   = 1'b0;
        unique case (r_sq_mode[SW])
            qrs_pkg::MD_ZERO: begin
                w_z1 = 1'b1;
                w_z2 = 1'b1;
            end
            qrs_pkg::MD_LIN: begin
                w_num1 = r_sq_nb[SW];
                w_z2   = 1'b1;
            end
            qrs_pkg::MD_CZERO: begin
                w_z1   = 1'b1;
                w_num2 = r_sq_nb[SW];
            end
            qrs_pkg::MD_BZ_REAL: begin
                w_num1 = -w_sx;
                w_num2 = w_sx;
            end
            qrs_pkg::MD_BZ_CPLX: begin
                w_z1   = 1'b1;
                w_num2 = w_sx;
            end
            qrs_pkg::MD_DBL: begin
                w_num1 = r_sq_nb[SW];
                w_num2 = r_sq_nb[SW];
            end
            qrs_pkg::MD_REAL: begin
                w_num1 = r_sq_nb[SW] - w_sx;
                w_num2 = r_sq_nb[SW] + w_sx;
            end
            qrs_pkg::MD_CPLX: begin
                w_num1 = r_sq_nb[SW];
                w_num2 = w_sx;
            end
            default: begin
                w_z1 = 1'b1;
                w_z2 = 1'b1;
            end
        endcase
        w_un1 = w_num1[NW-1] ? $unsigned(-w_num1) : $unsigned(w_num1);
        w_un2 = w_num2[NW-1] ? $unsigned(-w_num2) : $unsigned(w_num2);
        w_ud  = w_dsel[DNW-1] ? UDW'($unsigned(-w_dsel)) : UDW'($unsigned(w_dsel));
    end

    // divider pipe, index 0 is the setup register
    logic                  r_dv_vld  [0:NW];
    qrs_pkg::t_class       r_dv_cls  [0:NW];
    logic                  r_dv_z1   [0:NW];
    logic                  r_dv_z2   [0:NW];
    logic                  r_dv_neg1 [0:NW];
    logic                  r_dv_neg2 [0:NW];
    logic [UDW-1:0]        r_dv_ud   [0:NW];
    logic [NW-1:0]         r_dv_dd1  [0:NW];
    logic [NW-1:0]         r_dv_dd2  [0:NW];
    logic [UDW-1:0]        r_dv_rem1 [0:NW];
    logic [UDW-1:0]        r_dv_rem2 [0:NW];
    logic [NW-1:0]         r_dv_q1   [0:NW];
    logic [NW-1:0]         r_dv_q2   [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_sq_vld[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_cls[0]  <= r_sq_cls[SW];
            r_dv_z1[0]   <= w_z1;
            r_dv_z2[0]   <= w_z2;
            r_dv_neg1[0] <= w_num1[NW-1] ^ w_dsel[DNW-1];
            r_dv_neg2[0] <= w_num2[NW-1] ^ w_dsel[DNW-1];
            r_dv_ud[0]   <= w_ud;
            r_dv_dd1[0]  <= w_un1 + NW'(w_ud >> 1);
            r_dv_dd2[0]  <= w_un2 + NW'(w_ud >> 1);
            r_dv_rem1[0] <= '0;
            r_dv_rem2[0] <= '0;
            r_dv_q1[0]   <= '0;
            r_dv_q2[0]   <= '0;
        end
    end

    // ------------------------------------------------------------------
    // restoring division: one quotient bit per stage, both dividers
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NW; k++) begin : g_dv
        localparam int BIT = NW - 1 - k;
        logic [UDW:0] w_sh1, w_sh2;
        logic         w_t1, w_t2;

        always_comb begin
            w_sh1 = {r_dv_rem1[k], r_dv_dd1[k][BIT]};
            w_sh2 = {r_dv_rem2[k], r_dv_dd2[k][BIT]};
            w_t1  = (w_sh1 >= {1'b0, r_dv_ud[k]});
            w_t2  = (w_sh2 >= {1'b0, r_dv_ud[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem1[k+1] <= w_t1 ? UDW'(w_sh1 - {1'b0, r_dv_ud[k]}) : UDW'(w_sh1);
                r_dv_rem2[k+1] <= w_t2 ? UDW'(w_sh2 - {1'b0, r_dv_ud[k]}) : UDW'(w_sh2);
                r_dv_q1[k+1]   <= r_dv_q1[k] | (NW'(w_t1) << BIT);
                r_dv_q2[k+1]   <= r_dv_q2[k] | (NW'(w_t2) << BIT);
                r_dv_dd1[k+1]  <= r_dv_dd1[k];
                r_dv_dd2[k+1]  <= r_dv_dd2[k];
                r_dv_ud[k+1]   <= r_dv_ud[k];
                r_dv_cls[k+1]  <= r_dv_cls[k];
                r_dv_z1[k+1]   <= r_dv_z1[k];
                r_dv_z2[k+1]   <= r_dv_z2[k];
                r_dv_neg1[k+1] <= r_dv_neg1[k];
                r_dv_neg2[k+1] <= r_dv_neg2[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // sign and saturation
    // ------------------------------------------------------------------
    localparam logic [XW-1:0] LIM = XW'(1) << (OW - 1);

    logic [XW-1:0]        w_q1x, w_q2x, w_qs1, w_qs2;
    logic signed [OW-1:0] w_r1, w_r2;

    always_comb begin
        w_q1x = XW'(r_dv_q1[NW]);
        w_q2x = XW'(r_dv_q2[NW]);
        if (r_dv_neg1[NW]) begin
            w_qs1 = (w_q1x > LIM) ? LIM : w_q1x;
            w_r1  = OW'(-w_qs1);
        end else begin
            w_qs1 = (w_q1x > LIM - 1'b1) ? LIM - 1'b1 : w_q1x;
            w_r1  = OW'(w_qs1);
        end
        if (r_dv_neg2[NW]) begin
            w_qs2 = (w_q2x > LIM) ? LIM : w_q2x;
            w_r2  = OW'(-w_qs2);
        end else begin
            w_qs2 = (w_q2x > LIM - 1'b1) ? LIM - 1'b1 : w_q2x;
            w_r2  = OW'(w_qs2);
        end
        if (r_dv_z1[NW]) begin
            w_r1 = '0;
        end
        if (r_dv_z2[NW]) begin
            w_r2 = '0;
        end
    end

    logic                 r_pv_vld;
    qrs_pkg::t_class      r_pv_cls;
    logic signed [OW-1:0] r_pv_r1, r_pv_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv_vld <= 1'b0;
        end else if (en) begin
            r_pv_vld <= r_dv_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pv_cls <= r_dv_cls[NW];
            r_pv_r1  <= w_r1;
            r_pv_r2  <= w_r2;
        end
    end

    // ------------------------------------------------------------------
    // output register with one-word skid buffer
    // ------------------------------------------------------------------
    qrs_pkg::t_class      r_o_cls, r_sk_cls;
    logic signed [OW-1:0] r_o_r1, r_o_r2, r_sk_r1, r_sk_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (!r_o_vld || i_ready) begin
            if (r_sk_vld) begin
                r_o_vld  <= 1'b1;
                r_sk_vld <= 1'b0;
            end else begin
                r_o_vld  <= r_pv_vld;
            end
        end else if (en && r_pv_vld) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || i_ready) begin
            if (r_sk_vld) begin
                r_o_cls <= r_sk_cls;
                r_o_r1  <= r_sk_r1;
                r_o_r2  <= r_sk_r2;
            end else begin
                r_o_cls <= r_pv_cls;
                r_o_r1  <= r_pv_r1;
                r_o_r2  <= r_pv_r2;
            end
        end else if (en && r_pv_vld) begin
            r_sk_cls <= r_pv_cls;
            r_sk_r1  <= r_pv_r1;
            r_sk_r2  <= r_pv_r2;
        end
    end

    assign o_valid          = r_o_vld;
    assign o_solution_class = r_o_cls;
    assign o_root_first     = r_o_r1;
    assign o_root_second    = r_o_r2;

`ifndef NO_ASSERTIONS
    // skid word only exists behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_o_vld)
        else $error("skid buffer full with empty output register");

    // degenerate classes carry zero roots
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_solution_class == qrs_pkg::CLS_ALL
                  || o_solution_class == qrs_pkg::CLS_NONE))
        |-> (o_root_first == '0 && o_root_second == '0))
        else $error("nonzero root on degenerate class");

    // double root reports the same value twice
    a_double_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_solution_class == qrs_pkg::CLS_DOUBLE)
        |-> (o_root_first == o_root_second))
        else $error("double root fields differ");

    // linear case leaves the second field clear
    a_linear_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_solution_class == qrs_pkg::CLS_LINEAR)
        |-> (o_root_second == '0))
        else $error("linear class with nonzero second root");
`endif

endmodule : quadratic_root_solver

`default_nettype wire
